// File: sv/nmwu_pkg.sv
// Shared types, widths and constants of the Nesterov momentum weight update block.
package nmwu_pkg;

   // Field widths of the request, result and register set.
   localparam int IDX_W   = 12;
   localparam int WORD_W  = 32;
   localparam int MULT_W  = 16;
   localparam int BATCH_W = 11;
   localparam int LOSS_W  = 47;

   // Configuration port geometry: five registers at byte addresses 4*i.
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // Default depth of the velocity memory.
   localparam int PARAM_COUNT_DEF = 4096;

   // Datapath widths: shared multiplier operands and product, gradient numerator.
   localparam int OP_W   = 33;
   localparam int PROD_W = 66;
   localparam int GNUM_W = 42;
   localparam int G_W    = 43;

   // Register reset values.
   localparam logic [MULT_W-1:0]  LR_RESET       = 16'd655;
   localparam logic [MULT_W-1:0]  MOM_RESET      = 16'd58982;
   localparam logic [MULT_W-1:0]  STRENGTH_RESET = 16'd0;
   localparam logic [BATCH_W-1:0] BATCH_RESET    = 11'd1;

   // A group multiplier of zero stands for 1.0 in Q8.8.
   localparam logic [MULT_W:0] MULT_ONE = 17'd256;
   // 1.0 in Q0.16, added to the momentum factor for the weight step.
   localparam logic [MULT_W:0] Q16_ONE  = 17'd65536;
   // Ceiling of the saturating loss totals.
   localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};

   // Request commands.
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_LEARNING_RATE   = 3'd0,
      REG_MOMENTUM_FACTOR = 3'd1,
      REG_L1_STRENGTH     = 3'd2,
      REG_L2_STRENGTH     = 3'd3,
      REG_BATCH_COUNT     = 3'd4
   } reg_index_type;

   // Register contents as seen by the datapath.
   typedef struct packed {
      logic [MULT_W-1:0]  learning_rate;
      logic [MULT_W-1:0]  momentum_factor;
      logic [MULT_W-1:0]  l1_strength;
      logic [MULT_W-1:0]  l2_strength;
      logic [BATCH_W-1:0] batch_count;
   } cfg_type;

endpackage

// File: sv/nmwu_req_if.sv
// Request channel: one parameter update or a clear command.
interface nmwu_req_if;
   import nmwu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [IDX_W-1:0]         param_index;
   logic signed [WORD_W-1:0] weight_in;
   logic signed [WORD_W-1:0] grad_in;
   logic [MULT_W-1:0]        l1_mult;
   logic [MULT_W-1:0]        l2_mult;

   modport source (
      output valid, cmd, param_index, weight_in, grad_in, l1_mult, l2_mult,
      input  ready
   );

   modport sink (
      input  valid, cmd, param_index, weight_in, grad_in, l1_mult, l2_mult,
      output ready
   );
endinterface

// File: sv/nmwu_rsp_if.sv
// Result channel: updated weight and running decay loss totals.
interface nmwu_rsp_if;
   import nmwu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         index_out;
   logic signed [WORD_W-1:0] weight_out;
   logic [LOSS_W-1:0]        l1_loss_total;
   logic [LOSS_W-1:0]        l2_loss_total;

   modport source (
      output valid, index_out, weight_out, l1_loss_total, l2_loss_total,
      input  ready
   );

   modport sink (
      input  valid, index_out, weight_out, l1_loss_total, l2_loss_total,
      output ready
   );
endinterface

// File: sv/nesterov_momentum_weight_update.sv
// Top level: sequencer, shared multiplier and velocity memory of the weight update.
//
// One request is processed at a time. An update request goes from acceptance to
// its result through eleven steps of a single shared 33x33 multiplier (decay
// factors, weight square, losses, momentum and learning rate terms), the one-bit-
// per-cycle batch divider, and the adds and saturation; the velocity memory is read
// on acceptance and written back in the final state, so back-to-back requests to
// the same index always see the new velocity. A clear request goes straight from
// acceptance to the final state. After reset the velocity memory is zeroed by a
// pass over all PARAM_COUNT entries (4096 by default) during which no request is
// accepted; configuration writes are taken at any time. A finished result waits in
// an output register, and the next request is accepted while it waits.
module nesterov_momentum_weight_update #(
   parameter int PARAM_COUNT = nmwu_pkg::PARAM_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   nmwu_req_if.sink                      req_ch,
   nmwu_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nmwu_pkg::CSR_AW-1:0]   paddr,
   input  logic [nmwu_pkg::CSR_DW-1:0]   pwdata,
   output logic [nmwu_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import nmwu_pkg::*;

   localparam int ADDR_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PARAM_COUNT - 1);
   localparam int SAT_W = 46;
   localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(64'sd2147483647);
   localparam logic signed [SAT_W-1:0] S32_MIN = SAT_W'(-64'sd2147483648);

   typedef enum logic [17:0] {
      S_INIT = 18'h00001,
      S_IDLE = 18'h00002,
      S_D1   = 18'h00004,
      S_D2   = 18'h00008,
      S_SQ   = 18'h00010,
      S_L1   = 18'h00020,
      S_L2G  = 18'h00040,
      S_T1   = 18'h00080,
      S_T2   = 18'h00100,
      S_SUM  = 18'h00200,
      S_ACC  = 18'h00400,
      S_DVS  = 18'h00800,
      S_DIV  = 18'h01000,
      S_G1   = 18'h02000,
      S_G2   = 18'h04000,
      S_VN   = 18'h08000,
      S_NV   = 18'h10000,
      S_FIN  = 18'h20000
   } state_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic signed [WORD_W-1:0] r;
      if (x > S32_MAX) begin
         r = WORD_W'(S32_MAX);
      end else if (x < S32_MIN) begin
         r = WORD_W'(S32_MIN);
      end else begin
         r = WORD_W'(x);
      end
      return r;
   endfunction

   cfg_type cfg;

   // Sequencer and clearing pass.
   state_type                 state_ff, state_in;
   logic                      clr_pend_ff, clr_pend_in;
   logic [ADDR_W-1:0]         init_addr_ff, init_addr_in;

   // Request registers.
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [WORD_W-1:0]  w_ff, w_in;
   logic signed [WORD_W-1:0]  gr_ff, gr_in;
   logic [MULT_W:0]           m1_ff, m1_in;
   logic [MULT_W:0]           m2_ff, m2_in;
   logic                      in_store_ff, in_store_in;

   // Intermediate results.
   logic signed [WORD_W-1:0]  vold_ff, vold_in;
   logic [WORD_W-1:0]         d1_ff, d1_in;
   logic [WORD_W-1:0]         d2_ff, d2_in;
   logic [62:0]               sq_ff, sq_in;
   logic [39:0]               l1loss_ff, l1loss_in;
   logic signed [40:0]        l2g_ff, l2g_in;
   logic [62:0]               t1_ff, t1_in;
   logic [54:0]               l2loss_ff, l2loss_in;
   logic signed [WORD_W-1:0]  mv_ff, mv_in;
   logic signed [GNUM_W-1:0]  gnum_ff, gnum_in;
   logic signed [G_W-1:0]     g_ff, g_in;
   logic signed [43:0]        lrgh_ff, lrgh_in;
   logic signed [WORD_W-1:0]  vnew_ff, vnew_in;
   logic signed [PROD_W-1:0]  p_ff, p_in;

   // Running loss totals.
   logic [LOSS_W-1:0]         l1_tot_ff, l1_tot_in;
   logic [LOSS_W-1:0]         l2_tot_ff, l2_tot_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          rsp_idx_ff, rsp_idx_in;
   logic signed [WORD_W-1:0]  rsp_w_ff, rsp_w_in;
   logic [LOSS_W-1:0]         rsp_l1_ff, rsp_l1_in;
   logic [LOSS_W-1:0]         rsp_l2_ff, rsp_l2_in;

   // Combinational datapath signals.
   logic                      slot_free;
   logic                      mul_en;
   logic signed [OP_W-1:0]    a_op, b_op;
   logic signed [OP_W-1:0]    absw;
   logic [63:0]               l2sum;
   logic signed [GNUM_W-1:0]  l1g;
   logic [LOSS_W:0]           l1_acc_sum;
   logic [55:0]               l2_acc_sum;
   logic signed [SAT_W-1:0]   vsum;
   logic signed [33:0]        dx;
   logic signed [SAT_W-1:0]   wsum;
   logic [GNUM_W-1:0]         div_dividend;
   logic [BATCH_W-1:0]        div_divisor;
   logic                      div_start;
   logic                      div_done;
   logic [GNUM_W-1:0]         div_quot;
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [WORD_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [WORD_W-1:0]         ram_rd_data;

   nmwu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nmwu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PARAM_COUNT)
   ) u_velocity_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(req_ch.param_index)),
      .rd_data (ram_rd_data)
   );

   nmwu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Helper values shared by several steps.
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign absw         = w_ff[WORD_W-1] ? -OP_W'(w_ff) : OP_W'(w_ff);
   assign l2sum        = 64'(t1_ff) + 64'(p_ff[63:32]);
   assign l1g          = (w_ff > 0) ? GNUM_W'(d1_ff[WORD_W-1:8]) : -GNUM_W'(d1_ff[WORD_W-1:8]);
   assign l1_acc_sum   = (LOSS_W+1)'(l1_tot_ff) + (LOSS_W+1)'(l1loss_ff);
   assign l2_acc_sum   = 56'(l2_tot_ff) + 56'(l2loss_ff);
   assign vsum         = SAT_W'(mv_ff) + SAT_W'(lrgh_ff) + SAT_W'(p_ff[31:16]);
   assign dx           = 34'(mv_ff) - 34'($signed(p_ff[48:16]));
   assign wsum         = SAT_W'(w_ff) + SAT_W'(dx);
   assign div_dividend = gnum_ff[GNUM_W-1] ? GNUM_W'(-gnum_ff) : GNUM_W'(gnum_ff);
   assign div_divisor  = (cfg.batch_count == '0) ? BATCH_W'(1) : cfg.batch_count;

   // Sequencer: at most one multiplier step per state, product registered into p_ff.
   always_comb begin
      state_in     = state_ff;
      clr_pend_in  = clr_pend_ff;
      init_addr_in = init_addr_ff;
      idx_in       = idx_ff;
      w_in         = w_ff;
      gr_in        = gr_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      in_store_in  = in_store_ff;
      vold_in      = vold_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      sq_in        = sq_ff;
      l1loss_in    = l1loss_ff;
      l2g_in       = l2g_ff;
      t1_in        = t1_ff;
      l2loss_in    = l2loss_ff;
      mv_in        = mv_ff;
      gnum_in      = gnum_ff;
      g_in         = g_ff;
      lrgh_in      = lrgh_ff;
      vnew_in      = vnew_ff;
      l1_tot_in    = l1_tot_ff;
      l2_tot_in    = l2_tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_l1_in    = rsp_l1_ff;
      rsp_l2_in    = rsp_l2_ff;
      mul_en       = 1'b0;
      a_op         = '0;
      b_op         = '0;
      div_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = init_addr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            ram_wr_en = 1'b1;
            if (init_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               init_addr_in = init_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               idx_in      = req_ch.param_index;
               w_in        = req_ch.weight_in;
               gr_in       = req_ch.grad_in;
               m1_in       = (req_ch.l1_mult == '0) ? MULT_ONE : (MULT_W+1)'(req_ch.l1_mult);
               m2_in       = (req_ch.l2_mult == '0) ? MULT_ONE : (MULT_W+1)'(req_ch.l2_mult);
               in_store_in = 32'(req_ch.param_index) < 32'(PARAM_COUNT);
               clr_pend_in = (req_ch.cmd == CMD_CLEAR);
               ram_rd_en   = 1'b1;
               state_in    = (req_ch.cmd == CMD_CLEAR) ? S_FIN : S_D1;
            end
         end
         S_D1: begin
            vold_in  = in_store_ff ? $signed(ram_rd_data) : '0;
            mul_en   = 1'b1;
            a_op     = OP_W'(cfg.l1_strength);
            b_op     = OP_W'(m1_ff);
            state_in = S_D2;
         end
         S_D2: begin
            d1_in    = p_ff[WORD_W-1:0];
            mul_en   = 1'b1;
            a_op     = OP_W'(cfg.l2_strength);
            b_op     = OP_W'(m2_ff);
            state_in = S_SQ;
         end
         S_SQ: begin
            d2_in    = p_ff[WORD_W-1:0];
            mul_en   = 1'b1;
            a_op     = absw;
            b_op     = absw;
            state_in = S_L1;
         end
         S_L1: begin
            sq_in    = p_ff[62:0];
            mul_en   = 1'b1;
            a_op     = OP_W'(d1_ff);
            b_op     = absw;
            state_in = S_L2G;
         end
         S_L2G: begin
            l1loss_in = p_ff[63:24];
            mul_en    = 1'b1;
            a_op      = OP_W'(d2_ff);
            b_op      = OP_W'(w_ff);
            state_in  = S_T1;
         end
         S_T1: begin
            l2g_in   = $signed(p_ff[64:24]);
            mul_en   = 1'b1;
            a_op     = OP_W'(d2_ff);
            b_op     = OP_W'(sq_ff[62:32]);
            state_in = S_T2;
         end
         S_T2: begin
            t1_in    = p_ff[62:0];
            mul_en   = 1'b1;
            a_op     = OP_W'(d2_ff);
            b_op     = OP_W'(sq_ff[31:0]);
            state_in = S_SUM;
         end
         S_SUM: begin
            l2loss_in = l2sum[63:9];
            mul_en    = 1'b1;
            a_op      = OP_W'(cfg.momentum_factor);
            b_op      = OP_W'(vold_ff);
            state_in  = S_ACC;
         end
         S_ACC: begin
            mv_in     = $signed(p_ff[47:16]);
            gnum_in   = l1g + GNUM_W'(l2g_ff) + GNUM_W'(gr_ff);
            l1_tot_in = (l1_acc_sum >= (LOSS_W+1)'(LOSS_MAX)) ? LOSS_MAX
                                                              : l1_acc_sum[LOSS_W-1:0];
            l2_tot_in = (l2_acc_sum >= 56'(LOSS_MAX)) ? LOSS_MAX : l2_acc_sum[LOSS_W-1:0];
            state_in  = S_DVS;
         end
         S_DVS: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            // Truncating division: the quotient takes the sign of the numerator.
            if (div_done) begin
               g_in     = gnum_ff[GNUM_W-1] ? -G_W'(div_quot) : G_W'(div_quot);
               state_in = S_G1;
            end
         end
         S_G1: begin
            mul_en   = 1'b1;
            a_op     = OP_W'(cfg.learning_rate);
            b_op     = OP_W'($signed(g_ff[G_W-1:16]));
            state_in = S_G2;
         end
         S_G2: begin
            lrgh_in  = $signed(p_ff[43:0]);
            mul_en   = 1'b1;
            a_op     = OP_W'(cfg.learning_rate);
            b_op     = OP_W'(g_ff[15:0]);
            state_in = S_VN;
         end
         S_VN: begin
            vnew_in  = sat32(vsum);
            state_in = S_NV;
         end
         S_NV: begin
            mul_en   = 1'b1;
            a_op     = OP_W'(Q16_ONE + (MULT_W+1)'(cfg.momentum_factor));
            b_op     = OP_W'(vnew_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            // Hold here until the output register is free.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               state_in     = S_IDLE;
               if (clr_pend_ff) begin
                  l1_tot_in = '0;
                  l2_tot_in = '0;
                  rsp_w_in  = '0;
                  rsp_l1_in = '0;
                  rsp_l2_in = '0;
               end else begin
                  rsp_w_in    = sat32(wsum);
                  rsp_l1_in   = l1_tot_ff;
                  rsp_l2_in   = l2_tot_ff;
                  ram_wr_en   = in_store_ff;
                  ram_wr_addr = ADDR_W'(idx_ff);
                  ram_wr_data = vnew_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      p_in = mul_en ? a_op * b_op : p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_addr_ff <= '0;
         clr_pend_ff  <= 1'b0;
         l1_tot_ff    <= '0;
         l2_tot_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         clr_pend_ff  <= clr_pend_in;
         l1_tot_ff    <= l1_tot_in;
         l2_tot_ff    <= l2_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      w_ff        <= w_in;
      gr_ff       <= gr_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      in_store_ff <= in_store_in;
      vold_ff     <= vold_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      sq_ff       <= sq_in;
      l1loss_ff   <= l1loss_in;
      l2g_ff      <= l2g_in;
      t1_ff       <= t1_in;
      l2loss_ff   <= l2loss_in;
      mv_ff       <= mv_in;
      gnum_ff     <= gnum_in;
      g_ff        <= g_in;
      lrgh_ff     <= lrgh_in;
      vnew_ff     <= vnew_in;
      p_ff        <= p_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_l1_ff   <= rsp_l1_in;
      rsp_l2_ff   <= rsp_l2_in;
   end

   // Channel outputs.
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.index_out     = rsp_idx_ff;
   assign rsp_ch.weight_out    = rsp_w_ff;
   assign rsp_ch.l1_loss_total = rsp_l1_ff;
   assign rsp_ch.l2_loss_total = rsp_l2_ff;
endmodule

// File: sv/nmwu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nmwu_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/nmwu_csr.sv
// APB-style register file holding the step size, momentum, decay and batch settings.
module nmwu_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nmwu_pkg::CSR_AW-1:0]   paddr,
   input  logic [nmwu_pkg::CSR_DW-1:0]   pwdata,
   output logic [nmwu_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output nmwu_pkg::cfg_type             cfg
);
   import nmwu_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   logic [2:0]    reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[CSR_AW-1:2];

   // Register write decode; values are masked to the register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_LEARNING_RATE:   cfg_in.learning_rate   = pwdata[MULT_W-1:0];
            REG_MOMENTUM_FACTOR: cfg_in.momentum_factor = pwdata[MULT_W-1:0];
            REG_L1_STRENGTH:     cfg_in.l1_strength     = pwdata[MULT_W-1:0];
            REG_L2_STRENGTH:     cfg_in.l2_strength     = pwdata[MULT_W-1:0];
            REG_BATCH_COUNT:     cfg_in.batch_count     = pwdata[BATCH_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learning_rate   <= LR_RESET;
         cfg_ff.momentum_factor <= MOM_RESET;
         cfg_ff.l1_strength     <= STRENGTH_RESET;
         cfg_ff.l2_strength     <= STRENGTH_RESET;
         cfg_ff.batch_count     <= BATCH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_sel)
         REG_LEARNING_RATE:   prdata = CSR_DW'(cfg_ff.learning_rate);
         REG_MOMENTUM_FACTOR: prdata = CSR_DW'(cfg_ff.momentum_factor);
         REG_L1_STRENGTH:     prdata = CSR_DW'(cfg_ff.l1_strength);
         REG_L2_STRENGTH:     prdata = CSR_DW'(cfg_ff.l2_strength);
         REG_BATCH_COUNT:     prdata = CSR_DW'(cfg_ff.batch_count);
         default:             prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;
endmodule

// File: sv/nmwu_div.sv
// Restoring divider, one quotient bit per cycle, for the batch normalization.
module nmwu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [nmwu_pkg::GNUM_W-1:0]   dividend,
   input  logic [nmwu_pkg::BATCH_W-1:0]  divisor,
   output logic                          done,
   output logic [nmwu_pkg::GNUM_W-1:0]   quotient
);
   import nmwu_pkg::*;

   localparam int CNT_W = $clog2(GNUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GNUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BATCH_W-1:0]   rem_ff, rem_in;
   logic [GNUM_W-1:0]    quo_ff, quo_in;
   logic [BATCH_W-1:0]   div_ff, div_in;
   logic [BATCH_W:0]     trial;
   logic                 fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign trial = {rem_ff, quo_ff[GNUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? BATCH_W'(trial - {1'b0, div_ff}) : BATCH_W'(trial);
         quo_in = {quo_ff[GNUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: sv/nmwu_checker.sv
// Port-level assertions for the weight update block, bound to its top level.
module nmwu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [nmwu_pkg::IDX_W-1:0]          rsp_index_out,
   input logic signed [nmwu_pkg::WORD_W-1:0]  rsp_weight_out,
   input logic [nmwu_pkg::LOSS_W-1:0]         rsp_l1_loss_total,
   input logic [nmwu_pkg::LOSS_W-1:0]         rsp_l2_loss_total
);
   import nmwu_pkg::*;

   // A stalled result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index_out)
         && $stable(rsp_weight_out) && $stable(rsp_l1_loss_total)
         && $stable(rsp_l2_loss_total))
      else $error("result changed while stalled");

   // One request at a time: the block is busy right after taking a request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // A new result only appears after the block has been busy with a request.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared from idle");

   // The memory clearing pass after reset holds off requests.
   a_init_pass: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");
endmodule

bind nesterov_momentum_weight_update nmwu_checker u_nmwu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_index_out     (rsp_ch.index_out),
   .rsp_weight_out    (rsp_ch.weight_out),
   .rsp_l1_loss_total (rsp_ch.l1_loss_total),
   .rsp_l2_loss_total (rsp_ch.l2_loss_total)
);
